[design/iod_pkg.sv]
// ----------------------------------------------------------------------------
// iod_pkg
// shared constants, types and state codes of the interface omega damping block
// ----------------------------------------------------------------------------
package iod_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam logic [1:0] REG_LOWER = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;
  localparam logic [1:0] REG_BETA  = 2'd3;

  localparam logic [16:0] LOWER_RESET = 17'd0;
  localparam logic [16:0] UPPER_RESET = 17'd65536;
  localparam logic [15:0] GAIN_RESET  = 16'd256;
  localparam logic [15:0] BETA_RESET  = 16'd5898;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ROOT = 7'b0000010,
    ST_SQR  = 7'b0000100,
    ST_DEN  = 7'b0001000,
    ST_NUM  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

[design/iod_cbrt.sv]
// ----------------------------------------------------------------------------
// iod_cbrt
// bit-serial floor cube root of a 64-bit value, one root bit per cycle
// ----------------------------------------------------------------------------
module iod_cbrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [21:0] root
);

  logic [65:0] rem;
  logic [65:0] rem_next;
  logic [63:0] src;
  logic [21:0] y;
  logic [21:0] y_next;
  logic [4:0]  cnt;
  logic        busy;
  logic [22:0] ys;
  logic [66:0] b;
  logic [66:0] cur;

  // first step takes a single bit (bit 63), others three bits
  always_comb begin
    ys = {y, 1'b0};
    b = 67'(3) * 67'(ys) * 67'(ys + 23'd1) + 67'd1;
    if (cnt == 5'd0) begin
      cur = 67'({rem[63:0], src[63]});
    end else begin
      cur = 67'({rem[63:0], src[63:61]});
    end
    if (cur >= b) begin
      rem_next = 66'(cur - b);
      y_next   = ys[21:0] | 22'd1;
    end else begin
      rem_next = 66'(cur);
      y_next   = ys[21:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        rem  <= '0;
        y    <= '0;
        src  <= radicand;
      end else if (busy) begin
        rem <= rem_next;
        y   <= y_next;
        src <= (cnt == 5'd0) ? {src[62:0], 1'b0} : {src[60:0], 3'b000};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd21) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = y;

endmodule

[design/iod_div.sv]
// ----------------------------------------------------------------------------
// iod_div
// bit-serial restoring divider, 128-bit dividend by 64-bit divisor
// ----------------------------------------------------------------------------
module iod_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] dividend,
  input  logic [63:0]  divisor,
  output logic         done,
  output logic [63:0]  quotient,
  output logic         overflow
);

  logic [127:0] src;
  logic [64:0]  rem;
  logic [64:0]  shifted;
  logic [6:0]   cnt;
  logic         busy;
  logic         hit;

  assign shifted = {rem[63:0], src[127]};
  assign hit = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 7'd0;
        rem      <= '0;
        src      <= dividend;
        overflow <= 1'b0;
      end else if (busy) begin
        rem <= hit ? shifted - {1'b0, divisor} : shifted;
        src <= {src[126:0], 1'b0};
        if (cnt[6] == 1'b0) begin
          overflow <= overflow | hit;
        end else begin
          quotient <= {quotient[62:0], hit};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/interface_omega_damping.sv]
// ----------------------------------------------------------------------------
// interface_omega_damping
// interface turbulence damping of omega, one cell per request
// ----------------------------------------------------------------------------
// A cell whose phase fraction lies strictly between the limits is corrected:
// a bit-serial cube root, three multiplies and a bit-serial division make its
// result. Any other cell goes straight to the output state, which registers
// its result. One cell is processed at a time; the result waits in an output
// register and the next request is taken only after the result is accepted.
module interface_omega_damping (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_of_pass,
  input  logic [16:0] phase_fraction,
  input  logic [31:0] eddy_viscosity,
  input  logic [63:0] cell_volume,
  input  logic [63:0] omega_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] omega_out,
  output logic        was_corrected,
  output logic        saturated,
  output logic [31:0] corrected_so_far,
  output logic [31:0] cells_so_far
);

  localparam int CW = iod_pkg::COUNT_WIDTH;

  iod_pkg::state_t state;
  logic [16:0] lower_limit;
  logic [16:0] upper_limit;
  logic [15:0] damping_gain;
  logic [15:0] beta_star;
  logic [CW-1:0] corrected_count;
  logic [CW-1:0] total_count;
  logic [31:0] nut;
  logic [63:0] vol;
  logic [63:0] omega;
  logic        corr;
  logic [43:0] dx2;
  logic [63:0] den;
  logic [50:0] num;
  logic        cbrt_done;
  logic [21:0] root;
  logic        div_start;
  logic        div_done;
  logic        cbrt_start;
  logic [63:0] quo;
  logic        ovf;
  logic        in_window;
  logic [CW-1:0] cc_base;
  logic [CW-1:0] tc_base;

  assign in_ready = (state == iod_pkg::ST_IDLE) && !out_valid;
  assign in_window = (phase_fraction > lower_limit) && (phase_fraction < upper_limit);
  assign cc_base = start_of_pass ? '0 : corrected_count;
  assign tc_base = start_of_pass ? '0 : total_count;
  assign cbrt_start = (state == iod_pkg::ST_ROOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit  <= iod_pkg::LOWER_RESET;
      upper_limit  <= iod_pkg::UPPER_RESET;
      damping_gain <= iod_pkg::GAIN_RESET;
      beta_star    <= iod_pkg::BETA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        iod_pkg::REG_LOWER: lower_limit  <= cfg_data;
        iod_pkg::REG_UPPER: upper_limit  <= cfg_data;
        iod_pkg::REG_GAIN:  damping_gain <= cfg_data[15:0];
        iod_pkg::REG_BETA:  beta_star    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  iod_cbrt u_cbrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cbrt_start),
    .radicand (vol),
    .done     (cbrt_done),
    .root     (root)
  );

  iod_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({55'd0, num, 22'd0} << 20),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo),
    .overflow (ovf)
  );

  assign div_start = (state == iod_pkg::ST_NUM) && (den != 64'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= iod_pkg::ST_IDLE;
      out_valid       <= 1'b0;
      corrected_count <= '0;
      total_count     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        iod_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            nut   <= eddy_viscosity;
            vol   <= cell_volume;
            omega <= omega_in;
            corr  <= in_window;
            total_count <= (&tc_base) ? tc_base : tc_base + 1'b1;
            if (in_window) begin
              corrected_count <= (&cc_base) ? cc_base : cc_base + 1'b1;
              state <= iod_pkg::ST_ROOT;
            end else begin
              corrected_count <= cc_base;
              state <= iod_pkg::ST_OUT;
            end
          end
        end
        iod_pkg::ST_ROOT: begin
          state <= iod_pkg::ST_SQR;
        end
        iod_pkg::ST_SQR: begin
          if (cbrt_done) begin
            dx2   <= 44'(root) * 44'(root);
            state <= iod_pkg::ST_DEN;
          end
        end
        iod_pkg::ST_DEN: begin
          den   <= 64'(dx2) * 64'(beta_star);
          num   <= 51'(nut) * (51'({damping_gain, 2'b00}) + 51'({damping_gain, 1'b0}));
          state <= iod_pkg::ST_NUM;
        end
        iod_pkg::ST_NUM: begin
          if (den == 64'd0) begin
            omega <= '1;
            state <= iod_pkg::ST_OUT;
            saturated <= 1'b1;
          end else begin
            state <= iod_pkg::ST_DIV;
          end
        end
        iod_pkg::ST_DIV: begin
          if (div_done) begin
            omega     <= ovf ? '1 : quo;
            saturated <= ovf;
            state     <= iod_pkg::ST_OUT;
          end
        end
        iod_pkg::ST_OUT: begin
          if (!corr) begin
            saturated <= 1'b0;
          end
          omega_out        <= omega;
          was_corrected    <= corr;
          corrected_so_far <= 32'(corrected_count);
          cells_so_far     <= 32'(total_count);
          state            <= iod_pkg::ST_IDLE;
          out_valid        <= 1'b1;
        end
        default: state <= iod_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == iod_pkg::ST_IDLE))
    else $error("bad state");
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    corrected_count <= total_count)
    else $error("corrected count above total");
  a_sat_corr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> was_corrected)
    else $error("saturation without correction");
`endif

endmodule

[sim/tb_interface_omega_damping.sv]
// ----------------------------------------------------------------------------
// tb_interface_omega_damping
// regression of the interface omega damping block: directed corner cells, then
// random cells under several idle and stall phases, checked against a
// bit-accurate predictor through a small scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_interface_omega_damping;

  typedef struct {
    logic [63:0] omega;
    logic        corr;
    logic        sat;
    logic [31:0] ncorr;
    logic [31:0] ncells;
  } damp_res_t;

  class damp_scoreboard;
    logic [16:0] lo_lim, hi_lim;
    logic [15:0] gain, beta;
    logic [31:0] corr_cnt, cell_cnt;
    damp_res_t   pending[$];
    int          errors;

    function new();
      lo_lim = iod_pkg::LOWER_RESET;
      hi_lim = iod_pkg::UPPER_RESET;
      gain = iod_pkg::GAIN_RESET;
      beta = iod_pkg::BETA_RESET;
      corr_cnt = 0;
      cell_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        iod_pkg::REG_LOWER: lo_lim = val;
        iod_pkg::REG_UPPER: hi_lim = val;
        iod_pkg::REG_GAIN:  gain = val[15:0];
        iod_pkg::REG_BETA:  beta = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] cube_root(logic [63:0] x);
      logic [63:0] y, b;
      y = 0;
      for (int s = 63; s >= 0; s -= 3) begin
        y = y << 1;
        b = 3 * y * (y + 1) + 1;
        if ((x >> s) >= b) begin
          x = x - (b << s);
          y = y + 1;
        end
      end
      return y;
    endfunction

    function void note_cell(logic sop, logic [16:0] alpha, logic [31:0] nut,
                            logic [63:0] vol, logic [63:0] om);
      damp_res_t   r;
      logic [63:0] dx;
      logic [127:0] num, den, q;
      if (sop) begin
        corr_cnt = 0;
        cell_cnt = 0;
      end
      r.omega = om;
      r.corr = 0;
      r.sat = 0;
      if (alpha > lo_lim && alpha < hi_lim) begin
        dx = cube_root(vol);
        den = 128'(beta) * dx * dx;
        num = (128'(6) * gain * nut) << 42;
        r.corr = 1;
        if (den == 0) begin
          r.omega = '1;
          r.sat = 1;
        end else begin
          q = num / den;
          if (q[127:64] != 0) begin
            r.omega = '1;
            r.sat = 1;
          end else r.omega = q[63:0];
        end
        if (corr_cnt != '1) corr_cnt++;
      end
      if (cell_cnt != '1) cell_cnt++;
      r.ncorr = corr_cnt;
      r.ncells = cell_cnt;
      pending.push_back(r);
    endfunction

    function void check(logic [63:0] om, logic c, logic s, logic [31:0] nc,
                        logic [31:0] nt);
      damp_res_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result omega %h", $time, om);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (om !== e.omega || c !== e.corr || s !== e.sat || nc !== e.ncorr
          || nt !== e.ncells) begin
        $display("%0t mismatch exp %h %b %b %0d %0d act %h %b %b %0d %0d", $time,
                 e.omega, e.corr, e.sat, e.ncorr, e.ncells, om, c, s, nc, nt);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid, in_ready;
  logic        start_of_pass;
  logic [16:0] phase_fraction;
  logic [31:0] eddy_viscosity;
  logic [63:0] cell_volume, omega_in;
  logic        out_valid, out_ready;
  logic [63:0] omega_out;
  logic        was_corrected, saturated;
  logic [31:0] corrected_so_far, cells_so_far;

  damp_scoreboard sb;
  int send_idle, recv_stall;
  int cycles;
  localparam int CYCLE_LIMIT = 2000000;

  interface_omega_damping dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready)
      sb.check(omega_out, was_corrected, saturated, corrected_so_far, cells_so_far);
    if (cycles > CYCLE_LIMIT) begin
      $display("interface_omega_damping regression: fail");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  // leaves the request line high; drain, or an idle wait in the next send, takes it down
  task automatic send_cell(logic sop, logic [16:0] a, logic [31:0] n,
                           logic [63:0] v, logic [63:0] o);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    start_of_pass <= sop;
    phase_fraction <= a;
    eddy_viscosity <= n;
    cell_volume <= v;
    omega_in <= o;
    do @(posedge clk); while (!in_ready);
    sb.note_cell(sop, a, n, v, o);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_cells(int n);
    logic [63:0] v;
    logic [16:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: v = rnd64();
        1: v = 64'($urandom_range(4096));
        2: v = rnd64() >> $urandom_range(63);
        default: v = 64'd1 << $urandom_range(63);
      endcase
      a = ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                   : 17'($urandom_range(65536));
      if ($urandom_range(9) == 0) a = 17'(sb.lo_lim + $urandom_range(1));
      send_cell($urandom_range(15) == 0, a,
                ($urandom_range(1)) ? $urandom : $urandom >> $urandom_range(31),
                v, rnd64());
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_index = iod_pkg::REG_LOWER;
    cfg_data = 0;
    in_valid = 0;
    start_of_pass = 0;
    phase_fraction = 0;
    eddy_viscosity = 0;
    cell_volume = 0;
    omega_in = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed corners at reset settings
    send_cell(1, 17'd0, 32'd1000, 64'd1, 64'h1234);
    send_cell(0, 17'd65536, 32'd1000, 64'd8, 64'h5678);
    send_cell(0, 17'd1, '1, 64'd1, '0);
    send_cell(0, 17'd65535, '1, '1, '1);
    send_cell(0, 17'd32768, 32'd0, '1, '1);
    send_cell(0, 17'd32768, 32'd1, '1, 64'd0);
    send_cell(0, 17'd32768, 32'd12345, 64'd0, 64'd7);
    send_cell(0, 17'h1FFFF, '1, 64'd0, 64'h55);
    send_cell(1, 17'd100, 32'h8000_0000, 64'h8000_0000_0000_0000, 64'd9);
    send_cell(0, 17'd100, 32'd7, 64'd27, 64'd1);
    drain();
    set_reg(iod_pkg::REG_BETA, 17'd0);
    send_cell(0, 17'd500, 32'd1, 64'd1000, 64'd3);
    drain();
    set_reg(iod_pkg::REG_LOWER, 17'd65536);
    set_reg(iod_pkg::REG_UPPER, 17'd0);
    set_reg(iod_pkg::REG_GAIN, 17'd0);
    set_reg(iod_pkg::REG_BETA, 17'd65535);
    send_cell(0, 17'd40000, 32'd1, 64'd1, 64'd4);
    drain();
    set_reg(iod_pkg::REG_LOWER, 17'd0);
    set_reg(iod_pkg::REG_UPPER, 17'h1FFFF);
    set_reg(iod_pkg::REG_GAIN, 17'd65535);
    send_cell(0, 17'd65536, '1, 64'd1, 64'd5);
    send_cell(0, 17'h1FFFE, '1, '1, 64'd6);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 88; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 88; end
        3: begin send_idle = 23; recv_stall = 23; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      set_reg(iod_pkg::REG_LOWER, 17'($urandom_range(40000)));
      set_reg(iod_pkg::REG_UPPER, 17'($urandom_range(65536, 30000)));
      set_reg(iod_pkg::REG_GAIN, 17'($urandom_range(65535)));
      set_reg(iod_pkg::REG_BETA, 17'($urandom_range(65535, 1)));
      random_cells(125);
      drain();
      random_cells(125);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("interface_omega_damping regression: pass");
    else
      $display("interface_omega_damping regression: fail");
    $finish;
  end
endmodule
